// ===== src/sgs_pkg.sv =====
// Shared types, constants and the exponential weight table of the stroke smoother.
// Depends on nothing; every other file of the block but sgs_ram uses it.
`default_nettype none

package sgs_pkg;

	localparam int HISTORY_DEPTH_DEF = 128;
	localparam int EXP_TABLE_SIZE    = 256;
	localparam int EXP_IDX_W         = $clog2(EXP_TABLE_SIZE);
	localparam logic [31:0] EXP_STEP_Q32 = 32'd4034748382;
	localparam logic [6:0]  VEL_SCALE    = 7'd100;

	localparam int COORD_W = 24;
	localparam int VEL_W   = 16;
	localparam int WORD_W  = 2 * COORD_W + VEL_W;
	localparam int WGT_W   = 17;

	// Shared divider sizing: numerator, divisor and quotient bits.
	localparam int DIV_NUM_W = 49;
	localparam int DIV_DEN_W = 25;
	localparam int DIV_Q_W   = 24;
	localparam int DIV_CNT_W = 5;

	typedef logic [WGT_W-1:0] exp_tab_t [EXP_TABLE_SIZE];

	// Weight table: a Q32 accumulator scaled by exp(-1/16) per entry.
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t    t;
		logic [95:0] acc;
		acc = 96'd1 << 32;
		for (int k = 0; k < EXP_TABLE_SIZE; k++) begin
			t[k] = WGT_W'((acc + 96'h8000) >> 16);
			acc  = (acc * 96'(EXP_STEP_Q32) + (96'd1 << 31)) >> 32;
		end
		return t;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

	typedef enum logic [1:0] {
		CFG_ENABLE = 2'd0,
		CFG_WINDOW = 2'd1,
		CFG_SIGMA  = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STORE,
		ST_SIG,
		ST_CHK,
		ST_RD,
		ST_ACC,
		ST_SQ,
		ST_KDIV,
		ST_KWAIT,
		ST_MX,
		ST_MY,
		ST_AY,
		ST_FDX,
		ST_FDXW,
		ST_FDYW,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [VEL_W-1:0]          v;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} hist_word_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_CNT_W-1:0] qbits;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               ovf;
		logic [DIV_Q_W-1:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== src/sgs_in_if.sv =====
// Input channel of the stroke smoother: one stroke point per transaction.
// Depends on sgs_pkg for field widths.
`default_nettype none

interface sgs_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  new_stroke;
	logic signed [sgs_pkg::COORD_W-1:0]    point_x;
	logic signed [sgs_pkg::COORD_W-1:0]    point_y;
	logic [sgs_pkg::VEL_W-1:0]             point_velocity;

	modport source(output valid, new_stroke, point_x, point_y, point_velocity, input ready);
	modport sink(input valid, new_stroke, point_x, point_y, point_velocity, output ready);
endinterface

`default_nettype wire

// ===== src/sgs_out_if.sv =====
// Output channel of the stroke smoother: one smoothed point per transaction.
// Depends on sgs_pkg for field widths.
`default_nettype none

interface sgs_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [sgs_pkg::COORD_W-1:0] smoothed_x;
	logic signed [sgs_pkg::COORD_W-1:0] smoothed_y;

	modport source(output valid, smoothed_x, smoothed_y, input ready);
	modport sink(input valid, smoothed_x, smoothed_y, output ready);
endinterface

`default_nettype wire

// ===== src/sgs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the point history.
`default_nettype none

module sgs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/sgs_div.sv =====
// Shared restoring divider: one quotient bit per cycle, quotient width set per request.
// Depends on sgs_pkg for the request and response structs.
`default_nettype none

module sgs_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sgs_pkg::div_req_t req,
	output sgs_pkg::div_rsp_t      rsp
);
	import sgs_pkg::*;

	logic                 busy_q;
	logic                 ovf_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_Q_W-1:0]   lo_q;
	logic [DIV_Q_W-1:0]   quo_q;

	logic [DIV_NUM_W-1:0] hi;
	logic                 hi_ovf;
	logic [DIV_DEN_W:0]   rem_sh;
	logic                 ge;

	// Upper part of the numerator; if it already reaches the divisor the quotient overflows.
	assign hi     = req.num >> req.qbits;
	assign hi_ovf = hi >= DIV_NUM_W'(req.den);

	// One compare and subtract step.
	assign rem_sh = {rem_q, lo_q[DIV_Q_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= !hi_ovf;
			cnt_q  <= req.qbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (req.start) begin
			ovf_q <= hi_ovf;
			den_q <= req.den;
			rem_q <= hi[DIV_DEN_W-1:0];
			lo_q  <= req.num[DIV_Q_W-1:0] << (DIV_CNT_W'(DIV_Q_W) - req.qbits);
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_Q_W-2:0], ge};
			lo_q  <= lo_q << 1;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.ovf  = ovf_q;
	assign rsp.quo  = quo_q;

endmodule

`default_nettype wire

// ===== src/stroke_gaussian_smoother.sv =====
// Stroke smoother: gaussian weighted moving average over the newest stroke points.
// A point is passed through, only stored, or smoothed over len = min(window_length, stored
// points) entries; a smoothed point waits on the shared divider once per entry and once
// per final coordinate. One point at a time; the next point is taken in the cycle after
// its result is registered, once the block is back in idle.
// Reset (arst_n, asynchronous) empties the history and restores 0 / 20 / 20 config.
`default_nettype none

module stroke_gaussian_smoother #(
	parameter int HISTORY_DEPTH = sgs_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	sgs_in_if.sink           in_pt,
	sgs_out_if.source        out_pt,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [9:0]  cfg_data
);
	import sgs_pkg::*;

	localparam int SLOT_W = $clog2(HISTORY_DEPTH);
	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
	localparam int CMP_W  = (FILL_W > 8) ? FILL_W : 8;

	state_t state_q, state_d;

	logic        en_q;
	logic [7:0]  win_q;
	logic [9:0]  sigma_q;

	logic [SLOT_W-1:0] slot_q, rd_slot_q, rd_prev;
	logic [FILL_W-1:0] fill_q;

	hist_word_t pt_q;
	hist_word_t rd_word;
	logic [WORD_W-1:0] rdata;

	logic [7:0]  len_q, cnt_q;
	logic [30:0] ssum_q;
	logic [19:0] sig2_q;
	logic [WGT_W-1:0] w_q;
	logic [23:0] wsum_q;
	logic signed [47:0] ax_q, ay_q;
	logic signed [COORD_W-1:0] res_x_q, res_y_q;

	logic        out_valid_q;
	logic signed [COORD_W-1:0] ox_q, oy_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic        in_acc;
	logic        out_free;
	logic [47:0] mag;
	logic        mag_neg;
	logic [CMP_W-1:0] win_ext, fill_ext;
	logic        neg_q;

	assign in_acc   = in_pt.valid && in_pt.ready;
	assign out_free = !out_valid_q || out_pt.ready;
	assign rd_word  = hist_word_t'(rdata);
	assign rd_prev  = (rd_slot_q == '0) ? SLOT_W'(HISTORY_DEPTH - 1) : rd_slot_q - 1'b1;
	assign win_ext  = CMP_W'(win_q);
	assign fill_ext = CMP_W'(fill_q);

	// History memory: one entry per stored point.
	sgs_ram #(
		.WIDTH(WORD_W),
		.DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (state_q == ST_STORE),
		.waddr (slot_q),
		.wdata (pt_q),
		.re    (state_q == ST_RD),
		.raddr (rd_prev),
		.rdata (rdata)
	);

	sgs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Magnitude and sign of the accumulator being divided.
	always_comb begin
		mag_neg = (state_q == ST_FDX) ? ax_q[47] : ay_q[47];
		if (state_q == ST_FDX) begin
			mag = ax_q[47] ? 48'(-ax_q) : 48'(ax_q);
		end else begin
			mag = ay_q[47] ? 48'(-ay_q) : 48'(ay_q);
		end
	end

	// Sign register of the quotient being computed.
	always_ff @(posedge clk) begin
		if (div_req.start) begin
			neg_q <= mag_neg;
		end
	end

	// Next state, multiplier operands and divider requests.
	always_comb begin
		state_d       = state_q;
		mul_a         = '0;
		mul_b         = '0;
		div_req.start = 1'b0;
		div_req.qbits = DIV_CNT_W'(EXP_IDX_W);
		div_req.num   = DIV_NUM_W'(prod_q[62:29]);
		div_req.den   = DIV_DEN_W'(sig2_q);
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = (en_q && win_q != '0) ? ST_STORE : ST_FIN;
				end
			end
			ST_STORE: state_d = ST_SIG;
			ST_SIG: begin
				mul_a   = 32'(sigma_q);
				mul_b   = 32'(sigma_q);
				state_d = ST_CHK;
			end
			ST_CHK: begin
				state_d = (fill_q < FILL_W'(2) || sigma_q == '0) ? ST_FIN : ST_RD;
			end
			ST_RD:  state_d = ST_ACC;
			ST_ACC: state_d = ST_SQ;
			ST_SQ: begin
				mul_a   = {1'b0, ssum_q};
				mul_b   = {1'b0, ssum_q};
				state_d = ST_KDIV;
			end
			ST_KDIV: begin
				div_req.start = 1'b1;
				state_d       = ST_KWAIT;
			end
			ST_KWAIT: begin
				if (!div_rsp.busy) begin
					state_d = ST_MX;
				end
			end
			ST_MX: begin
				mul_a   = 32'(w_q);
				mul_b   = 32'(rd_word.x);
				state_d = ST_MY;
			end
			ST_MY: begin
				mul_a   = 32'(w_q);
				mul_b   = 32'(rd_word.y);
				state_d = ST_AY;
			end
			ST_AY: state_d = (cnt_q == len_q) ? ST_FDX : ST_RD;
			ST_FDX: begin
				div_req.qbits = DIV_CNT_W'(DIV_Q_W);
				div_req.num   = DIV_NUM_W'({mag, 1'b0}) + DIV_NUM_W'(wsum_q);
				div_req.den   = DIV_DEN_W'({wsum_q, 1'b0});
				if (wsum_q == '0) begin
					state_d = ST_FIN;
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_FDXW;
				end
			end
			ST_FDXW: begin
				// Launch the y division as soon as x is done.
				div_req.qbits = DIV_CNT_W'(DIV_Q_W);
				div_req.num   = DIV_NUM_W'({mag, 1'b0}) + DIV_NUM_W'(wsum_q);
				div_req.den   = DIV_DEN_W'({wsum_q, 1'b0});
				if (!div_rsp.busy) begin
					div_req.start = 1'b1;
					state_d       = ST_FDYW;
				end
			end
			ST_FDYW: begin
				if (!div_rsp.busy) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q    <= 1'b0;
			win_q   <= 8'd20;
			sigma_q <= 10'd20;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ENABLE: en_q    <= cfg_data[0];
				CFG_WINDOW: win_q   <= cfg_data[7:0];
				CFG_SIGMA:  sigma_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// History pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
		end else if (in_acc && in_pt.new_stroke) begin
			slot_q <= '0;
			fill_q <= '0;
		end else if (state_q == ST_STORE) begin
			slot_q <= (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			if (fill_q < FILL_W'(HISTORY_DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Walk counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			len_q <= '0;
		end else if (state_q == ST_CHK) begin
			cnt_q <= '0;
			len_q <= (win_ext < fill_ext) ? win_q : 8'(fill_q);
		end else if (state_q == ST_RD) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Datapath: multiplier product and accumulators.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					pt_q.x  <= in_pt.point_x;
					pt_q.y  <= in_pt.point_y;
					pt_q.v  <= in_pt.point_velocity;
					res_x_q <= in_pt.point_x;
					res_y_q <= in_pt.point_y;
				end
			end
			ST_CHK: begin
				sig2_q    <= prod_q[19:0];
				rd_slot_q <= slot_q;
				ssum_q    <= '0;
				wsum_q    <= '0;
				ax_q      <= '0;
				ay_q      <= '0;
				if (fill_q >= FILL_W'(2)) begin
					res_x_q <= '0;
					res_y_q <= '0;
				end
			end
			ST_RD: rd_slot_q <= rd_prev;
			ST_ACC: ssum_q <= ssum_q + 31'(rd_word.v) * 31'(VEL_SCALE);
			ST_KWAIT: begin
				if (!div_rsp.busy) begin
					w_q <= div_rsp.ovf ? '0 : EXP_TAB[div_rsp.quo[EXP_IDX_W-1:0]];
				end
			end
			ST_MX: wsum_q <= wsum_q + 24'(w_q);
			ST_MY: ax_q <= ax_q + prod_q[47:0];
			ST_AY: ay_q <= ay_q + prod_q[47:0];
			ST_FDXW: begin
				if (!div_rsp.busy) begin
					res_x_q <= neg_q ? -div_rsp.quo : div_rsp.quo;
				end
			end
			ST_FDYW: begin
				if (!div_rsp.busy) begin
					res_y_q <= neg_q ? -div_rsp.quo : div_rsp.quo;
				end
			end
			default: ;
		endcase
	end

	// Output register: holds the result until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_pt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			ox_q <= res_x_q;
			oy_q <= res_y_q;
		end
	end

	assign in_pt.ready       = (state_q == ST_IDLE);
	assign out_pt.valid      = out_valid_q;
	assign out_pt.smoothed_x = ox_q;
	assign out_pt.smoothed_y = oy_q;

	// The history count never passes the ring depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(HISTORY_DEPTH))
		else $error("history count beyond depth");

	// The walk never reads more entries than the clamped window.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= len_q)
		else $error("walk beyond window");

	// The divider only runs while the sequencer waits on it.
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> (state_q == ST_KWAIT || state_q == ST_FDXW || state_q == ST_FDYW))
		else $error("divider busy outside a wait state");

	// An accepted point always starts work.
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != ST_IDLE)
		else $error("accepted point dropped");

endmodule

`default_nettype wire

// ===== tb/sgs_checker.sv =====
// Checker of the stroke smoother: watches both point channels and the register port,
// predicts every smoothed point and compares it with what the block delivers.
// Depends on sgs_pkg and on the sgs_in_if and sgs_out_if interfaces.
`timescale 1ns / 100ps

module sgs_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	sgs_in_if                in_mon,
	sgs_out_if               out_mon,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [9:0]  cfg_data,
	output int               pending,
	output int               failures,
	output int               checked,
	output int               smoothed
);
	import sgs_pkg::*;

	localparam int DEPTH = 128;
	localparam int TAB_N = 256;

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} point_t;

	// Expected smoothed points, oldest first.
	point_t expected_points[$];

	// Own copy of the configuration and of the history ring.
	logic               enable_q;
	logic [7:0]         window_q;
	logic [9:0]         sigma_q;
	logic [COORD_W-1:0] ring_x [DEPTH];
	logic [COORD_W-1:0] ring_y [DEPTH];
	logic [VEL_W-1:0]   ring_v [DEPTH];
	int                 next_slot;
	int                 stored;
	longint unsigned    weight_tab [TAB_N];

	// Gaussian weights: exp(-k/16) in Q16, stepped down by a Q32 factor.
	initial begin
		logic [127:0] acc;
		acc = 128'd1 << 32;
		for (int k = 0; k < TAB_N; k++) begin
			weight_tab[k] = longint'((acc + 128'h8000) >> 16);
			acc = (acc * 128'd4034748382 + (128'd1 << 31)) >> 32;
		end
	end

	// Division rounded to nearest with halves away from zero.
	function automatic longint round_div(longint num, longint unsigned den);
		longint unsigned mag;
		longint unsigned q;
		mag = (num < 0) ? longint'(-num) : longint'(num);
		q = (2 * mag + den) / (2 * den);
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	// Predicts the smoothed point for one stroke point and updates the history.
	function automatic point_t smooth_point(logic ns, logic [COORD_W-1:0] px,
			logic [COORD_W-1:0] py, logic [VEL_W-1:0] pv);
		point_t            r;
		int                len;
		int                slot;
		longint unsigned   vsum;
		longint unsigned   wsum;
		longint unsigned   den;
		longint unsigned   k;
		longint unsigned   w;
		longint            ax;
		longint            ay;
		r.x = px;
		r.y = py;
		if (ns) begin
			stored = 0;
			next_slot = 0;
		end
		if (!enable_q || window_q == 0)
			return r;
		ring_x[next_slot] = px;
		ring_y[next_slot] = py;
		ring_v[next_slot] = pv;
		next_slot = (next_slot + 1 >= DEPTH) ? 0 : next_slot + 1;
		if (stored < DEPTH)
			stored++;
		if (stored < 2)
			return r;
		r.x = '0;
		r.y = '0;
		if (sigma_q == 0)
			return r;
		smoothed++;
		len = (window_q < stored) ? window_q : stored;
		den = (longint'(sigma_q) * longint'(sigma_q)) << 29;
		slot = next_slot;
		vsum = 0;
		wsum = 0;
		ax = 0;
		ay = 0;
		for (int i = 0; i < len; i++) begin
			slot = (slot == 0) ? DEPTH - 1 : slot - 1;
			vsum += 100 * longint'(ring_v[slot]);
			k = (vsum * vsum) / den;
			w = (k < TAB_N) ? weight_tab[k] : 0;
			wsum += w;
			ax += longint'(w) * longint'($signed(ring_x[slot]));
			ay += longint'(w) * longint'($signed(ring_y[slot]));
		end
		if (wsum != 0) begin
			r.x = COORD_W'(round_div(ax, wsum));
			r.y = COORD_W'(round_div(ay, wsum));
		end
		return r;
	endfunction

	assign pending = expected_points.size();

	// Register writes, then results before new points within one edge.
	always @(posedge clk or negedge arst_n) begin
		point_t got;
		point_t want;
		if (!arst_n) begin
			enable_q <= 1'b0;
			window_q <= 8'd20;
			sigma_q <= 10'd20;
			next_slot = 0;
			stored = 0;
			expected_points.delete();
			failures = 0;
			checked = 0;
			smoothed = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_ENABLE: enable_q <= cfg_data[0];
					CFG_WINDOW: window_q <= cfg_data[7:0];
					CFG_SIGMA: sigma_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_mon.valid && out_mon.ready) begin
				got.x = out_mon.smoothed_x;
				got.y = out_mon.smoothed_y;
				if (expected_points.size() == 0) begin
					$error("smoothed point with no point outstanding: x %0d y %0d",
						$signed(got.x), $signed(got.y));
					failures++;
				end else begin
					want = expected_points.pop_front();
					checked++;
					if (got.x !== want.x) begin
						$error("smoothed_x: expected %0d, actual %0d",
							$signed(want.x), $signed(got.x));
						failures++;
					end
					if (got.y !== want.y) begin
						$error("smoothed_y: expected %0d, actual %0d",
							$signed(want.y), $signed(got.y));
						failures++;
					end
				end
			end
			if (in_mon.valid && in_mon.ready)
				expected_points.push_back(smooth_point(in_mon.new_stroke, in_mon.point_x,
					in_mon.point_y, in_mon.point_velocity));
		end
	end
endmodule

// ===== tb/tb.sv =====
// Top of the stroke smoother testbench: clock, reset, point stimulus, result stalls
// and the verdict. Depends on sgs_pkg, both channel interfaces and sgs_checker.
`timescale 1ns / 100ps

module tb;
	import sgs_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [9:0] cfg_data;
	int         pending;
	int         failures;
	int         checked;
	int         smoothed;
	int         sent;
	bit         hold_output;
	bit         calm;

	sgs_in_if  in_pt();
	sgs_out_if out_pt();

	stroke_gaussian_smoother dut (
		.clk(clk), .arst_n(arst_n), .in_pt(in_pt), .out_pt(out_pt),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	sgs_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_mon(in_pt), .out_mon(out_pt),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pending(pending), .failures(failures), .checked(checked), .smoothed(smoothed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Generous upper bound on the whole run.
	initial begin
		#40000000;
		$display("FAILURE");
		$finish;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 20);
		return $urandom_range(50, 200);
	endfunction

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int n;
		out_pt.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_output) begin
				out_pt.ready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_output = 1'b0;
			end
			n = gap_length();
			if (n > 0) begin
				out_pt.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_pt.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Writes all three registers once no point is offered or in flight.
	task automatic write_config(logic en, logic [7:0] win, logic [9:0] sig);
		in_pt.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ENABLE;
		cfg_data <= {9'd0, en};
		@(posedge clk);
		cfg_index <= CFG_WINDOW;
		cfg_data <= {2'd0, win};
		@(posedge clk);
		cfg_index <= CFG_SIGMA;
		cfg_data <= sig;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one stroke point and waits for its transaction, then maybe idles.
	task automatic send_point(logic ns, logic [23:0] x, logic [23:0] y, logic [15:0] v);
		int n;
		in_pt.valid <= 1'b1;
		in_pt.new_stroke <= ns;
		in_pt.point_x <= x;
		in_pt.point_y <= y;
		in_pt.point_velocity <= v;
		@(posedge clk);
		while (!in_pt.ready) @(posedge clk);
		sent++;
		n = gap_length();
		if (n > 0) begin
			in_pt.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Velocity: mostly slow so that weights stay alive, sometimes anything.
	function automatic logic [15:0] pick_velocity();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 16'($urandom_range(0, 2000));
		if (r < 9)
			return 16'($urandom_range(0, 20000));
		return 16'($urandom);
	endfunction

	initial begin
		logic        en;
		logic [7:0]  win;
		logic [9:0]  sig;
		logic [23:0] px;
		logic [23:0] py;
		logic        ns;
		int          items;
		cfg_we = 1'b0;
		cfg_index = CFG_ENABLE;
		cfg_data = '0;
		in_pt.valid = 1'b0;
		in_pt.new_stroke = 1'b0;
		in_pt.point_x = '0;
		in_pt.point_y = '0;
		in_pt.point_velocity = '0;
		hold_output = 1'b0;
		calm = 1'b0;
		sent = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pass-through at reset values, field extremes.
		send_point(1'b1, 24'h7FFFFF, 24'h800000, 16'hFFFF);
		send_point(1'b0, 24'h800000, 24'h7FFFFF, 16'h0000);
		send_point(1'b0, 24'hFFFFFF, 24'h000000, 16'h8000);
		// A window as deep as the history, a wide sigma, extremes averaged together.
		write_config(1'b1, 8'd128, 10'd1000);
		send_point(1'b1, 24'h7FFFFF, 24'h7FFFFF, 16'h0000);
		send_point(1'b0, 24'h800000, 24'h800000, 16'h0001);
		send_point(1'b0, 24'h7FFFFF, 24'h800000, 16'hFFFF);
		send_point(1'b0, 24'h000001, 24'hFFFFFF, 16'h0100);
		// A window of one point.
		write_config(1'b1, 8'd1, 10'd20);
		send_point(1'b1, 24'h001234, 24'h004321, 16'h0010);
		send_point(1'b0, 24'h001300, 24'h004400, 16'h0020);
		// Zero sigma gives the origin once two points are stored.
		write_config(1'b1, 8'd5, 10'd0);
		send_point(1'b1, 24'h010000, 24'h020000, 16'h0040);
		send_point(1'b0, 24'h010100, 24'h020100, 16'h0040);
		send_point(1'b0, 24'h010200, 24'h020200, 16'h0040);
		// A zero window passes points through and stores nothing.
		write_config(1'b1, 8'd0, 10'd500);
		send_point(1'b0, 24'h123456, 24'h654321, 16'h1000);
		send_point(1'b0, 24'hABCDEF, 24'hFEDCBA, 16'h2000);
		// Narrow sigma and fast motion: every weight vanishes.
		write_config(1'b1, 8'd10, 10'd1);
		send_point(1'b1, 24'h000100, 24'h000200, 16'hFFFF);
		send_point(1'b0, 24'h000300, 24'h000400, 16'hFFFF);
		send_point(1'b0, 24'h000500, 24'h000600, 16'hFFFF);
		// Window wider than the history, widest sigma code.
		write_config(1'b1, 8'd255, 10'd1023);
		send_point(1'b1, 24'h000800, 24'h000900, 16'h0300);
		send_point(1'b0, 24'h000A00, 24'h000B00, 16'h0300);
		send_point(1'b0, 24'h000C00, 24'h000D00, 16'h0300);

		// Random phases of strokes along a drifting path.
		for (int ph = 0; ph < 11; ph++) begin
			en = ($urandom_range(0, 7) != 0);
			case ($urandom_range(0, 5))
				0: win = 8'($urandom_range(0, 2));
				1, 2: win = 8'($urandom_range(3, 12));
				3: win = 8'($urandom_range(13, 40));
				4: win = 8'($urandom_range(0, 255));
				default: win = 8'($urandom_range(1, 20));
			endcase
			case ($urandom_range(0, 5))
				0: sig = 10'd0;
				1: sig = 10'd1023;
				2: sig = 10'($urandom_range(1, 30));
				default: sig = 10'($urandom_range(20, 1000));
			endcase
			items = 70;
			if (ph == 4) begin
				en = 1'b1;
				win = 8'd128;
				sig = 10'd1000;
				items = 150;
			end
			write_config(en, win, sig);
			calm = (ph == 7);
			if (ph == 2)
				hold_output = 1'b1;
			px = 24'($urandom);
			py = 24'($urandom);
			for (int i = 0; i < items; i++) begin
				ns = ($urandom_range(0, 24) == 0);
				if ($urandom_range(0, 4) == 0) begin
					px = 24'($urandom);
					py = 24'($urandom);
				end else begin
					px = px + 24'($signed(11'($urandom)));
					py = py + 24'($signed(11'($urandom)));
				end
				if (ph == 4)
					send_point(ns && i < 20, px, py, 16'($urandom_range(0, 300)));
				else
					send_point(ns, px, py, pick_velocity());
			end
		end
		in_pt.valid <= 1'b0;
		calm = 1'b0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (2200) @(posedge clk);
		$display("Run: %0d stroke points sent, %0d results checked, %0d of them averaged.",
			sent, checked, smoothed);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
